@@ rtl/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types and constants shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam int SIZE_BITS_DEF = 24;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_F  = 8'h66;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_F  = 8'h46;
	localparam logic [7:0] CHAR_LO_X  = 8'h78;
	localparam logic [7:0] CHAR_UP_X  = 8'h58;

	typedef enum logic [2:0] {
		OC_PAYLOAD    = 3'd0,
		OC_DONE       = 3'd1,
		OC_BAD_SIZE   = 3'd2,
		OC_SHORT_DATA = 3'd3,
		OC_NO_CRLF    = 3'd4,
		OC_OVERFLOW   = 3'd5
	} outcome_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       final_byte;
	} body_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		outcome_t   outcome;
	} result_t;

	// Byte as seen by the parser: raw value plus its character classes.
	typedef struct packed {
		logic [7:0] raw;
		logic       fin;
		logic [3:0] digit;
		logic       is_hex;
		logic       is_blank;
		logic       is_cr;
		logic       is_lf;
		logic       is_plus;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
	} byte_class_t;

endpackage

@@ rtl/hcbd_front.sv @@
// ----------------------------------------------------------------------------
// hcbd_front
// Input handshake and character classification of each body byte.
// ----------------------------------------------------------------------------
module hcbd_front import hcbd_pkg::*; (
	input  logic        body_valid,
	output logic        body_stall,
	input  body_t       body,
	input  logic        queue_full,
	output logic        push,
	output byte_class_t cls
);

	logic [7:0] b;

	assign b          = body.body_byte;
	assign body_stall = queue_full;
	assign push       = body_valid & ~queue_full;

	always_comb begin
		cls          = '0;
		cls.raw      = b;
		cls.fin      = body.final_byte;
		cls.is_cr    = (b == CHAR_CR);
		cls.is_lf    = (b == CHAR_LF);
		cls.is_plus  = (b == CHAR_PLUS);
		cls.is_minus = (b == CHAR_MINUS);
		cls.is_zero  = (b == CHAR_ZERO);
		cls.is_x     = (b == CHAR_LO_X) || (b == CHAR_UP_X);
		cls.is_blank = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) ||
			(b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
		if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
			cls.is_hex = 1'b1;
			cls.digit  = b[3:0];
		end else if ((b >= CHAR_LO_A && b <= CHAR_LO_F) ||
				(b >= CHAR_UP_A && b <= CHAR_UP_F)) begin
			// Letters a-f and A-F share their low three bits: 1..6 maps to 10..15.
			cls.is_hex = 1'b1;
			cls.digit  = 4'(b[2:0] + 3'd1) + 4'd8;
		end
	end

endmodule

@@ rtl/hcbd_queue.sv @@
// ----------------------------------------------------------------------------
// hcbd_queue
// Small first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module hcbd_queue import hcbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  byte_class_t push_data,
	input  logic        pop,
	output byte_class_t head,
	output logic        not_empty,
	output logic        full
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	byte_class_t         mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_BITS'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/hcbd_back.sv @@
// ----------------------------------------------------------------------------
// hcbd_back
// Chunk parser: size line, payload count, trailing CR LF, and result register.
// ----------------------------------------------------------------------------
module hcbd_back import hcbd_pkg::*; #(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  byte_class_t head,
	input  logic        not_empty,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result
);

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_SIGNED = 3'd1,
		PH_ZERO   = 3'd2,
		PH_DIGITS = 3'd3,
		PH_TAIL   = 3'd4,
		PH_DATA   = 3'd5,
		PH_TRAIL  = 3'd6,
		PH_SINK   = 3'd7
	} phase_t;

	phase_t                 phase_q, phase_n, sub;
	logic [SIZE_BITS-1:0]   size_q, size_n;
	logic [SIZE_BITS-1:0]   left_q, left_n;
	logic                   neg_q, neg_n;
	logic                   cr_q, cr_n;
	logic                   emit;
	logic                   handled;
	result_t                res;
	logic                   result_valid_q;
	result_t                result_q;
	logic [SIZE_BITS-1:0]   size_shifted;
	logic                   size_full;

	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pop          = not_empty & (~result_valid_q | ~result_stall);

	assign size_shifted = {size_q[SIZE_BITS-5:0], head.digit};
	assign size_full    = (size_q[SIZE_BITS-1 -: 4] != 4'd0);

	always_comb begin
		phase_n          = phase_q;
		size_n           = size_q;
		left_n           = left_q;
		neg_n            = neg_q;
		cr_n             = cr_q;
		emit             = 1'b0;
		handled          = 1'b0;
		sub              = phase_q;
		res.payload_byte = 8'd0;
		res.outcome      = OC_PAYLOAD;

		case (phase_q)
			PH_DATA: begin
				emit = 1'b1;
				if (head.fin) begin
					res.outcome = (left_q <= SIZE_BITS'(1)) ? OC_NO_CRLF : OC_SHORT_DATA;
				end else begin
					res.payload_byte = head.raw;
					left_n = left_q - SIZE_BITS'(1);
					if (left_q == SIZE_BITS'(1)) begin
						phase_n = PH_TRAIL;
						cr_n    = 1'b0;
					end
				end
			end
			PH_TRAIL: begin
				if (!cr_q) begin
					if (head.is_cr) begin
						cr_n = 1'b1;
					end else begin
						emit        = 1'b1;
						res.outcome = OC_NO_CRLF;
						phase_n     = PH_SINK;
					end
				end else begin
					if (head.is_lf) begin
						phase_n = PH_LEAD;
						size_n  = '0;
						neg_n   = 1'b0;
						cr_n    = 1'b0;
					end else begin
						emit        = 1'b1;
						res.outcome = OC_NO_CRLF;
						phase_n     = PH_SINK;
					end
				end
				if (head.fin && !emit) begin
					emit        = 1'b1;
					res.outcome = (phase_n == PH_LEAD) ? OC_DONE : OC_NO_CRLF;
				end
			end
			PH_SINK: begin
				phase_n = PH_SINK;
			end
			default: begin
				if (cr_q && head.is_lf) begin
					cr_n = 1'b0;
					if (size_q == '0) begin
						emit        = 1'b1;
						res.outcome = OC_DONE;
						phase_n     = PH_SINK;
					end else if (neg_q) begin
						emit        = 1'b1;
						res.outcome = OC_BAD_SIZE;
						phase_n     = PH_SINK;
					end else begin
						left_n  = size_q;
						phase_n = PH_DATA;
						if (head.fin) begin
							emit        = 1'b1;
							res.outcome = OC_SHORT_DATA;
						end
					end
				end else begin
					cr_n = head.is_cr;
					// Blanks and a sign before the digits are consumed without any
					// end-of-message check.
					if (phase_q == PH_LEAD) begin
						if (head.is_blank) begin
							handled = 1'b1;
						end else if (head.is_plus) begin
							handled = 1'b1;
							phase_n = PH_SIGNED;
						end else if (head.is_minus) begin
							handled = 1'b1;
							neg_n   = 1'b1;
							phase_n = PH_SIGNED;
						end else begin
							sub = PH_SIGNED;
						end
					end
					if (!handled) begin
						case (sub)
							PH_SIGNED: begin
								if (head.is_zero) begin
									phase_n = PH_ZERO;
								end else if (head.is_hex) begin
									size_n  = size_shifted;
									phase_n = PH_DIGITS;
								end else begin
									phase_n = PH_TAIL;
								end
							end
							PH_ZERO: begin
								if (head.is_x) begin
									phase_n = PH_DIGITS;
								end else if (head.is_hex) begin
									size_n  = size_shifted;
									phase_n = PH_DIGITS;
								end else begin
									phase_n = PH_TAIL;
								end
							end
							PH_DIGITS: begin
								if (head.is_hex) begin
									if (size_full) begin
										emit        = 1'b1;
										res.outcome = OC_OVERFLOW;
										phase_n     = PH_SINK;
									end else begin
										size_n = size_shifted;
									end
								end else begin
									phase_n = PH_TAIL;
								end
							end
							default: begin
								phase_n = sub;
							end
						endcase
						if (head.fin && !emit) begin
							emit        = 1'b1;
							res.outcome = OC_BAD_SIZE;
						end
					end
				end
			end
		endcase

		if (head.fin) begin
			phase_n = PH_LEAD;
			size_n  = '0;
			left_n  = '0;
			neg_n   = 1'b0;
			cr_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_LEAD;
			size_q         <= '0;
			left_q         <= '0;
			neg_q          <= 1'b0;
			cr_q           <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				size_q  <= size_n;
				left_q  <= left_n;
				neg_q   <= neg_n;
				cr_q    <= cr_n;
			end
			if (pop && emit) begin
				result_valid_q <= 1'b1;
				result_q       <= res;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/http_chunked_body_decoder.sv @@
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes a chunked HTTP/1.1 message body into payload bytes and end or
// error results.
// ----------------------------------------------------------------------------
// The block takes one body beat per clock and gives at most one result beat
// per body beat, so it sustains one byte per cycle while the result side keeps
// up. An accepted beat goes into a four-entry queue, and the parser takes it
// from the queue head and registers its result beat in the result register;
// the queue lets the body side keep sending for four beats while the result
// side stalls. The parser handles size lines, payload bytes and the trailing
// CR LF at one byte per cycle while the result side keeps up, and the final
// byte of a message always returns the parser to the start of a size line.
module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    body_valid,
	output logic    body_stall,
	input  body_t   body,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	byte_class_t cls;
	byte_class_t head;
	logic        push;
	logic        pop;
	logic        queue_full;
	logic        not_empty;

	hcbd_front u_front (
		.body_valid (body_valid),
		.body_stall (body_stall),
		.body       (body),
		.queue_full (queue_full),
		.push       (push),
		.cls        (cls)
	);

	hcbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (queue_full)
	);

	hcbd_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
